[rtl/ipr_pkg.sv]
`default_nettype none

package ipr_pkg;

	// Geometry and counters
	localparam int COORD_BITS = 16;
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int LIM_W      = 15;
	localparam int LSQ_W      = 2 * LIM_W;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int ABS_W      = COORD_BITS;
	localparam int SQ_W       = 2 * ABS_W;
	localparam int SUM_W      = SQ_W + 1;

	localparam logic [CNT_W-1:0] POINT_CAP = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] KEPT_CAP  =
		(MAX_POINTS < 2047) ? CNT_W'(MAX_POINTS) : CNT_W'(2047);
	localparam logic [CNT_W-1:0] INDEX_TOP = CNT_W'({IDX_W{1'b1}});
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(100);

	// Command queue between classifier and emitter
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified point word: what to emit for it, in order prev, cur, first
	typedef struct packed {
		logic                         keep_prev;
		logic                         keep_cur;
		logic                         keep_first;
		logic                         last;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic [IDX_W-1:0]             pidx;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [IDX_W-1:0]             cidx;
		logic signed [COORD_BITS-1:0] fx;
		logic signed [COORD_BITS-1:0] fy;
	} ipr_cmd_t;

	typedef struct packed {
		logic     push;
		ipr_cmd_t cmd;
	} ipr_push_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} ipr_qstat_t;

	typedef struct packed {
		logic                         pt_valid;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [IDX_W-1:0]             index;
		logic [CNT_W-1:0]             kept;
		logic                         eos;
	} ipr_res_t;

	// Magnitude of the difference of two coordinates
	function automatic logic [ABS_W-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [DIFF_W-1:0] d;
		logic signed [DIFF_W-1:0] nd;
		d  = DIFF_W'(a) - DIFF_W'(b);
		nd = -d;
		return d[DIFF_W-1] ? nd[ABS_W-1:0] : d[ABS_W-1:0];
	endfunction

	// Clamp a point number to the index field
	function automatic logic [IDX_W-1:0] sat_index(input logic [CNT_W-1:0] n);
		return (n > INDEX_TOP) ? {IDX_W{1'b1}} : n[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/isolated_point_removal_core.sv]
`default_nettype none
// Result path: a point is decided when the next point of its scan arrives, a scan's last point
// on its own arrival; its result then passes the difference stage, square stage, queue write
// and output register, in that order.
// Throughput: one point per cycle while in_ready is high; the emitter gives one result per
// cycle while res_ready allows, and a scan-final point yields up to three results.
// Reset: arst_n asynchronously clears counters, flags, queue and output valid, and
// loads the limit with 100; no clearing pass is needed.

module isolated_point_removal_core import ipr_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] in_x,
	input  wire logic signed [COORD_BITS-1:0] in_y,
	input  wire logic                         scan_last,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [LIM_W-1:0]             cfg_data,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic                              out_valid,
	output logic signed [15:0]                out_x,
	output logic signed [15:0]                out_y,
	output logic [IDX_W-1:0]                  out_index,
	output logic [CNT_W-1:0]                  kept_count,
	output logic                              end_of_scan
);

	ipr_push_t  qpush;
	ipr_qstat_t qstat;
	ipr_cmd_t   head;
	ipr_res_t   res;
	logic       pop;

	ipr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_x      (in_x),
		.in_y      (in_y),
		.scan_last (scan_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.qpush     (qpush)
	);

	ipr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	ipr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Drive result fields
	assign out_valid   = res.pt_valid;
	assign out_x       = res.x;
	assign out_y       = res.y;
	assign out_index   = res.index;
	assign kept_count  = res.kept;
	assign end_of_scan = res.eos;

`ifndef SYNTHESIS
	// Admission credit keeps the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.push |-> (qstat.count < QCNT_W'(QDEPTH)))
		else $error("command queue overflow");

	// Emitter never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("command queue underflow");

	// An empty marker only closes a scan
	a_marker_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (end_of_scan && (out_index == '0)))
		else $error("empty marker without end of scan");
`endif

endmodule

`default_nettype wire

[rtl/ipr_front.sv]
`default_nettype none

module ipr_front import ipr_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] in_x,
	input  wire logic signed [COORD_BITS-1:0] in_y,
	input  wire logic                         scan_last,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [LIM_W-1:0]             cfg_data,
	input  wire ipr_qstat_t                   qstat,
	output ipr_push_t                         qpush
);

	logic                         accept;
	logic [QCNT_W:0]              need;

	// Configuration and squared limit
	logic [LIM_W-1:0]             lim_q;
	logic [LSQ_W-1:0]             limsq_q;

	// Point tracking at accept
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic [CNT_W-1:0]             cnt_q;

	// Stage 1: differences
	logic                         v_s1, last_s1, zero_s1, one_s1;
	logic [ABS_W-1:0]             dx_s1, dy_s1, wx_s1, wy_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, cx_s1, cy_s1, fx_s1, fy_s1;
	logic [IDX_W-1:0]             pidx_s1, cidx_s1;

	// Stage 2: squares
	logic                         v_s2, last_s2, zero_s2, one_s2;
	logic [SQ_W-1:0]              sdx_s2, sdy_s2, swx_s2, swy_s2;
	logic signed [COORD_BITS-1:0] px_s2, py_s2, cx_s2, cy_s2, fx_s2, fy_s2;
	logic [IDX_W-1:0]             pidx_s2, cidx_s2;

	// Scan flags
	logic                         pbc_q, fp_q;
	logic                         close, wrap, kp, kc, kf, pbc_n, fp_n;

	// Admit a word only if the queue has room for everything in flight
	assign need     = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, v_s1}
		+ {{QCNT_W{1'b0}}, v_s2};
	assign in_ready = need < (QCNT_W + 1)'(QDEPTH);
	assign accept   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Hold the limit and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q   <= LIMIT_RESET;
			limsq_q <= LSQ_W'(LIMIT_RESET) * LSQ_W'(LIMIT_RESET);
		end else begin
			if (cfg_valid) begin
				lim_q <= cfg_data;
			end
			limsq_q <= LSQ_W'(lim_q) * LSQ_W'(lim_q);
		end
	end

	// Advance the point counter per accepted word, saturating at its top; clear it at a scan's last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (scan_last) begin
				cnt_q <= '0;
			end else if (cnt_q < POINT_CAP) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Remember previous and first point
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			if (cnt_q == '0) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
			end
		end
	end

	// Stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: neighbour and wrap differences
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= scan_last;
			zero_s1 <= (cnt_q == '0);
			one_s1  <= (cnt_q == CNT_W'(1));
			dx_s1   <= abs_diff(in_x, prev_x_q);
			dy_s1   <= abs_diff(in_y, prev_y_q);
			wx_s1   <= abs_diff(in_x, first_x_q);
			wy_s1   <= abs_diff(in_y, first_y_q);
			px_s1   <= prev_x_q;
			py_s1   <= prev_y_q;
			cx_s1   <= in_x;
			cy_s1   <= in_y;
			fx_s1   <= first_x_q;
			fy_s1   <= first_y_q;
			pidx_s1 <= sat_index(cnt_q - CNT_W'(1));
			cidx_s1 <= sat_index(cnt_q);
		end
	end

	// Stage 2: squares
	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_s2 <= last_s1;
			zero_s2 <= zero_s1;
			one_s2  <= one_s1;
			sdx_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			sdy_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
			swx_s2  <= SQ_W'(wx_s1) * SQ_W'(wx_s1);
			swy_s2  <= SQ_W'(wy_s1) * SQ_W'(wy_s1);
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
			pidx_s2 <= pidx_s1;
			cidx_s2 <= cidx_s1;
		end
	end

	// Classify: compare distances and decide what to keep
	always_comb begin
		close = (SUM_W'(sdx_s2) + SUM_W'(sdy_s2)) < SUM_W'(limsq_q);
		wrap  = (SUM_W'(swx_s2) + SUM_W'(swy_s2)) < SUM_W'(limsq_q);
		priority if (zero_s2) begin
			kp    = 1'b0;
			pbc_n = 1'b0;
			fp_n  = 1'b0;
		end else if (one_s2) begin
			kp    = close;
			pbc_n = close;
			fp_n  = !close;
		end else begin
			kp    = close || pbc_q;
			pbc_n = close;
			fp_n  = fp_q;
		end
		kc = last_s2 && !zero_s2 && (pbc_n || wrap);
		kf = last_s2 && !zero_s2 && fp_n && wrap;
	end

	// Hold the scan flags; clear them at the end of a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbc_q <= 1'b0;
			fp_q  <= 1'b0;
		end else if (v_s2) begin
			pbc_q <= last_s2 ? 1'b0 : pbc_n;
			fp_q  <= last_s2 ? 1'b0 : fp_n;
		end
	end

	// Push only words that emit something or end a scan
	always_comb begin
		qpush.push           = v_s2 && (kp || kc || kf || last_s2);
		qpush.cmd.keep_prev  = kp;
		qpush.cmd.keep_cur   = kc;
		qpush.cmd.keep_first = kf;
		qpush.cmd.last       = last_s2;
		qpush.cmd.px         = px_s2;
		qpush.cmd.py         = py_s2;
		qpush.cmd.pidx       = pidx_s2;
		qpush.cmd.cx         = cx_s2;
		qpush.cmd.cy         = cy_s2;
		qpush.cmd.cidx       = cidx_s2;
		qpush.cmd.fx         = fx_s2;
		qpush.cmd.fy         = fy_s2;
	end

endmodule

`default_nettype wire

[rtl/ipr_queue.sv]
`default_nettype none

module ipr_queue import ipr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ipr_push_t qpush,
	input  wire logic      pop,
	output ipr_cmd_t       head,
	output ipr_qstat_t     qstat
);

	ipr_cmd_t          mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head        = mem[rptr_q];
	assign qstat.count = cnt_q;
	assign qstat.empty = (cnt_q == '0);

	// Write entry at tail
	always_ff @(posedge clk) begin
		if (qpush.push) begin
			mem[wptr_q] <= qpush.cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (qpush.push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			unique case ({qpush.push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/ipr_back.sv]
`default_nettype none

module ipr_back import ipr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ipr_cmd_t   head,
	input  wire ipr_qstat_t qstat,
	output logic            pop,
	output logic            res_valid,
	input  wire logic       res_ready,
	output ipr_res_t        res
);

	logic [2:0]       done_q;
	logic [CNT_W-1:0] kc_q;
	logic             rv_q;
	ipr_res_t         res_q;

	logic             take, emit, only;
	logic [2:0]       flags, sel;
	logic [CNT_W-1:0] kc_inc;
	ipr_res_t         nxt;

	assign res_valid = rv_q;
	assign res       = res_q;

	// Pick the next result of the head word
	always_comb begin
		take   = !qstat.empty && (!rv_q || res_ready);
		flags  = {head.keep_first, head.keep_cur, head.keep_prev} & ~done_q;
		sel    = flags & (~flags + 3'd1);
		only   = (flags & (flags - 3'd1)) == 3'd0;
		kc_inc = (kc_q < KEPT_CAP) ? kc_q + CNT_W'(1) : kc_q;
		nxt    = '0;
		emit   = 1'b0;
		pop    = 1'b0;
		if (take) begin
			if (flags != 3'd0) begin
				emit         = 1'b1;
				pop          = only;
				nxt.pt_valid = 1'b1;
				nxt.kept     = kc_inc;
				nxt.eos      = head.last && only;
				priority if (sel[0]) begin
					nxt.x     = head.px;
					nxt.y     = head.py;
					nxt.index = head.pidx;
				end else if (sel[1]) begin
					nxt.x     = head.cx;
					nxt.y     = head.cy;
					nxt.index = head.cidx;
				end else begin
					nxt.x     = head.fx;
					nxt.y     = head.fy;
					nxt.index = '0;
				end
			end else begin
				// Empty end marker, or drop a word with nothing left
				emit     = head.last;
				pop      = 1'b1;
				nxt.kept = kc_q;
				nxt.eos  = head.last;
			end
		end
	end

	// Track progress inside the head word, the kept count and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			kc_q   <= '0;
			rv_q   <= 1'b0;
		end else begin
			if (take) begin
				done_q <= pop ? 3'd0 : (done_q | sel);
				if (emit) begin
					kc_q <= nxt.eos ? '0 : nxt.kept;
				end
			end
			if (emit) begin
				rv_q <= 1'b1;
			end else if (res_ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= nxt;
		end
	end

endmodule

`default_nettype wire
